// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/ciat_pkg.sv -----
// ----------------------------------------------------------------------------
// ciat_pkg
// Types, constants and operation codes of the idle connection aging table.
// ----------------------------------------------------------------------------
package ciat_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
   localparam int TIME_BITS   = 32;

   localparam logic [31:0] LIMIT_RESET = 32'd60;

   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_REMOVE   = 2'd1;
   localparam logic [1:0] OP_UPDATE   = 2'd2;
   localparam logic [1:0] OP_SWEEP    = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  slot;
      logic [31:0] time_value;
   } req_type;

   typedef struct packed {
      logic       status;
      logic       closed_valid;
      logic [7:0] closed_slot;
      logic       last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic single_op;
      logic sweep_load;
      logic sweep_read;
      logic final_emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_addr;
   } stat_type;

endpackage

// ----- hw/rtl/idle_connection_aging_table.sv -----
// ----------------------------------------------------------------------------
// idle_connection_aging_table
// Table of connection slots with last-activity stamps and idle-time aging.
// ----------------------------------------------------------------------------
// A command word is taken on req_data at a rising edge where start is high
// and busy is low. Register, remove and update touch one slot: the result
// word appears on rsp_data with rsp_strobe high in the next cycle, and busy
// stays low, so one such command can be taken every cycle.
// A sweep raises busy while the controller walks the stamp memory, one slot
// per cycle through its single registered read port. Each closed slot gives
// one word, in ascending slot order; the final word of the sweep, marked by
// last, comes in the cycle after busy falls, when a new command may already
// be taken. Every result word is on the result ports for exactly one cycle;
// the receiver cannot stall, so it must take each strobed word as it comes.
// The idle limit is written through csr_we and csr_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset clears all valid marks at once and sets the limit to 60; the stamp
// memory needs no clearing, since a stamp is read only behind a valid mark.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module idle_connection_aging_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ciat_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ciat_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);
   import ciat_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     accept;

   // The controller owns the sequencing; the datapath owns all storage.
   ciat_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_data.kind),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   ciat_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   assign accept = start && !busy;

   // A single-slot command answers with one final word in the next cycle.
   `ASSERT_CLK(a_single_answer, clock, reset, (accept && (req_data.kind != OP_SWEEP)) |=> (rsp_strobe && rsp_data.last), "single-slot command gave no final word")

   // A sweep holds the block busy while it walks the table.
   `ASSERT_CLK(a_sweep_busy, clock, reset, (accept && (req_data.kind == OP_SWEEP)) |=> busy, "sweep did not raise busy")

   // A word that names no closed slot always ends its command and carries slot zero.
   `ASSERT_CLK(a_no_close_word, clock, reset, (rsp_strobe && !rsp_data.closed_valid) |-> (rsp_data.last && (rsp_data.closed_slot == 8'd0)), "word without closed slot is malformed")

   // The controller issues at most one command per cycle.
   `ASSERT_NEVER(a_one_cmd, clock, reset, !$onehot0({cmd.single_op, cmd.sweep_load, cmd.sweep_read, cmd.final_emit}), "controller issued overlapping commands")

endmodule

// ----- hw/rtl/ciat_ctrl.sv -----
// ----------------------------------------------------------------------------
// ciat_ctrl
// Controller: accepts commands and sequences the sweep walk over the table.
// ----------------------------------------------------------------------------
module ciat_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         kind,
   input  ciat_pkg::stat_type stat,
   output ciat_pkg::cmd_type  cmd,
   output logic               busy
);
   import ciat_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (kind == OP_SWEEP) begin
                  cmd.sweep_load = 1'b1;
                  state_in       = ST_SWEEP;
               end else begin
                  cmd.single_op = 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep_read = 1'b1;
            if (stat.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.final_emit = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- hw/rtl/ciat_dp.sv -----
// ----------------------------------------------------------------------------
// ciat_dp
// Datapath: valid marks, stamp memory, idle compare and result register.
// ----------------------------------------------------------------------------
module ciat_dp (
   input  logic               clock,
   input  logic               reset,
   input  ciat_pkg::req_type  req_data,
   input  logic               csr_we,
   input  logic [31:0]        csr_wdata,
   input  ciat_pkg::cmd_type  cmd,
   output ciat_pkg::stat_type stat,
   output logic               rsp_strobe,
   output ciat_pkg::rsp_type  rsp_data
);
   import ciat_pkg::*;

   logic [31:0]            limit_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] valid_in;
   logic [TIME_BITS-1:0]   stamp_mem [TABLE_DEPTH];
   logic [TIME_BITS-1:0]   rd_data_ff;
   logic [TIME_BITS-1:0]   sweep_time_ff;
   logic [SLOT_BITS-1:0]   cnt_ff;
   logic [SLOT_BITS-1:0]   cnt_in;
   logic                   cmp_en_ff;
   logic [SLOT_BITS-1:0]   cmp_idx_ff;
   logic                   pend_valid_ff;
   logic                   pend_valid_in;
   logic [SLOT_BITS-1:0]   pend_slot_ff;
   logic [SLOT_BITS-1:0]   pend_slot_in;
   logic                   rsp_strobe_ff;
   logic                   rsp_strobe_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic [SLOT_BITS-1:0] req_idx;
   logic                 in_range;
   logic                 mem_we;
   logic [TIME_BITS-1:0] mem_wdata;
   logic                 single_status;
   logic [TIME_BITS-1:0] span;
   logic                 hit;

   assign req_idx   = req_data.slot[SLOT_BITS-1:0];
   assign in_range  = ({1'b0, req_data.slot} < 9'(TABLE_DEPTH));
   assign mem_wdata = TIME_BITS'(req_data.time_value);

   // Idle span wraps modulo the time width.
   assign span = sweep_time_ff - rd_data_ff;
   assign hit  = cmp_en_ff && valid_ff[cmp_idx_ff] && (64'(span) > 64'(limit_ff));

   always_comb begin
      valid_in      = valid_ff;
      mem_we        = 1'b0;
      single_status = 1'b0;
      if (cmd.single_op) begin
         if (!in_range) begin
            single_status = 1'b1;
         end else begin
            unique case (req_data.kind)
               OP_REGISTER: begin
                  valid_in[req_idx] = 1'b1;
                  mem_we            = 1'b1;
               end
               OP_REMOVE: begin
                  valid_in[req_idx] = 1'b0;
               end
               OP_UPDATE: begin
                  if (valid_ff[req_idx]) begin
                     mem_we = 1'b1;
                  end else begin
                     single_status = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      if (hit) begin
         valid_in[cmp_idx_ff] = 1'b0;
      end
   end

   // A closed slot is held back one step so that the last one can be marked.
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      priority if (cmd.single_op) begin
         rsp_strobe_in = 1'b1;
         rsp_in.status = single_status;
         rsp_in.last   = 1'b1;
      end else if (cmd.final_emit) begin
         rsp_strobe_in       = 1'b1;
         rsp_in.closed_valid = pend_valid_ff;
         rsp_in.closed_slot  = pend_valid_ff ? 8'(pend_slot_ff) : 8'd0;
         rsp_in.last         = 1'b1;
         pend_valid_in       = 1'b0;
      end else if (hit) begin
         if (pend_valid_ff) begin
            rsp_strobe_in       = 1'b1;
            rsp_in.closed_valid = 1'b1;
            rsp_in.closed_slot  = 8'(pend_slot_ff);
         end
         pend_valid_in = 1'b1;
         pend_slot_in  = cmp_idx_ff;
      end else if (cmd.sweep_load) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.sweep_load) begin
         cnt_in = '0;
      end else if (cmd.sweep_read) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   assign stat.last_addr = (cnt_ff == SLOT_BITS'(TABLE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[req_idx] <= mem_wdata;
      end
      if (cmd.sweep_read) begin
         rd_data_ff <= stamp_mem[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         cmp_en_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         cmp_en_ff     <= cmd.sweep_read;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cnt_ff;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
      if (cmd.sweep_load) begin
         sweep_time_ff <= mem_wdata;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
